>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to compile out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> hw/rtl/kcrb_pkg.sv
// ----------------------------------------------------------------------------
// kcrb_pkg
// Constants, types and HID code tables of the keyboard change-report builder.
// ----------------------------------------------------------------------------
package kcrb_pkg;

  localparam int KEY_COUNT    = 256;
  localparam int REPORT_SLOTS = 6;
  localparam int OUT_SLOTS    = 6;

  localparam int KEY_AW  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int FILL_W  = $clog2(REPORT_SLOTS + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd1;

  // Layout codes
  localparam logic LAYOUT_QWERTY = 1'b0;
  localparam logic LAYOUT_AZERTY = 1'b1;

  typedef logic [7:0] hid_code_t;

  typedef struct packed {
    logic              en;
    logic [KEY_AW-1:0] addr;
  } key_rd_t;

  typedef struct packed {
    logic              en;
    logic [KEY_AW-1:0] addr;
    logic              level;
  } key_wr_t;

  typedef struct packed {
    logic [7:0] key_index;
    logic       key_down;
    logic [7:0] modifier_bits;
    logic       scan_last;
  } key_item_t;

  localparam hid_code_t QWERTY_ROM [256] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2A,8'h2B,8'h00,8'h00,8'h00,8'h28,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h48,8'h39,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h29,8'h00,8'h00,8'h00,8'h00,
    8'h2C,8'h4B,8'h4E,8'h4D,8'h4A,8'h50,8'h52,8'h4F,8'h51,8'h00,8'h00,8'h00,8'h46,8'h49,8'h4C,8'h00,
    8'h27,8'h1E,8'h1F,8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0A,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,8'h10,8'h11,8'h12,
    8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1A,8'h1B,8'h1C,8'h1D,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h62,8'h59,8'h5A,8'h5B,8'h5C,8'h5D,8'h5E,8'h5F,8'h60,8'h61,8'h55,8'h57,8'h00,8'h56,8'h63,8'h54,
    8'h3A,8'h3B,8'h3C,8'h3D,8'h3E,8'h3F,8'h40,8'h41,8'h42,8'h43,8'h44,8'h45,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h53,8'h47,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h33,8'h2E,8'h36,8'h2D,8'h37,8'h38,
    8'h35,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2F,8'h32,8'h30,8'h34,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
  };

  localparam hid_code_t AZERTY_ROM [256] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2A,8'h2B,8'h00,8'h00,8'h00,8'h28,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h48,8'h39,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h29,8'h00,8'h00,8'h00,8'h00,
    8'h2C,8'h4B,8'h4E,8'h4D,8'h4A,8'h50,8'h52,8'h4F,8'h51,8'h00,8'h00,8'h00,8'h46,8'h49,8'h4C,8'h00,
    8'h27,8'h1E,8'h1F,8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h14,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0A,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,8'h33,8'h11,8'h12,
    8'h13,8'h04,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1D,8'h1B,8'h1C,8'h1A,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h62,8'h59,8'h5A,8'h5B,8'h5C,8'h5D,8'h5E,8'h5F,8'h60,8'h61,8'h55,8'h57,8'h00,8'h56,8'h63,8'h54,
    8'h3A,8'h3B,8'h3C,8'h3D,8'h3E,8'h3F,8'h40,8'h41,8'h42,8'h43,8'h44,8'h45,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h53,8'h47,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h30,8'h2E,8'h10,8'h00,8'h36,8'h37,
    8'h34,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2D,8'h32,8'h2F,8'h00,8'h38,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
  };

  function automatic hid_code_t hid_lookup(input logic layout, input logic [7:0] idx);
    hid_code_t code;
    if (layout == LAYOUT_AZERTY) begin
      code = AZERTY_ROM[idx];
    end else begin
      code = QWERTY_ROM[idx];
    end
    return code;
  endfunction

endpackage

>>> hw/rtl/kcrb_ifs.sv
// ----------------------------------------------------------------------------
// kcrb channel interfaces
// Key sample, report and configuration write channels (valid/ready).
// ----------------------------------------------------------------------------
interface kcrb_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_index;
  logic       key_down;
  logic [7:0] modifier_bits;
  logic       scan_last;

  modport source (output valid, key_index, key_down, modifier_bits, scan_last,
                  input ready);
  modport sink   (input valid, key_index, key_down, modifier_bits, scan_last,
                  output ready);
endinterface

interface kcrb_report_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_modifiers;
  logic [7:0] slot0_code;
  logic [7:0] slot1_code;
  logic [7:0] slot2_code;
  logic [7:0] slot3_code;
  logic [7:0] slot4_code;
  logic [7:0] slot5_code;

  modport source (output valid, report_modifiers, slot0_code, slot1_code, slot2_code,
                         slot3_code, slot4_code, slot5_code,
                  input ready);
  modport sink   (input valid, report_modifiers, slot0_code, slot1_code, slot2_code,
                        slot3_code, slot4_code, slot5_code,
                  output ready);
endinterface

interface kcrb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [kcrb_pkg::CFG_IDX_W-1:0]   index;
  logic [kcrb_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/kcrb_ram.sv
// ----------------------------------------------------------------------------
// kcrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kcrb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/kcrb_key_state.sv
// ----------------------------------------------------------------------------
// kcrb_key_state
// Remembered key levels: RAM plus per-key valid bits, with write bypass.
// ----------------------------------------------------------------------------
module kcrb_key_state (
  input  logic              clk,
  input  logic              rst,
  input  kcrb_pkg::key_rd_t rd,
  input  kcrb_pkg::key_wr_t wr,
  output logic              prior
);

  logic [kcrb_pkg::KEY_COUNT-1:0] key_vld;
  logic                           ram_level;
  logic                           rd_vld;
  logic                           byp;
  logic                           byp_level;

  kcrb_ram #(
    .WIDTH (1),
    .DEPTH (kcrb_pkg::KEY_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.level),
    .re    (rd.en),
    .raddr (rd.addr),
    .rdata (ram_level)
  );

  // Unwritten keys read as released.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_vld <= '0;
    end else if (wr.en) begin
      key_vld[wr.addr] <= 1'b1;
    end
  end

  // Forward a write landing on the same edge as the read.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_vld    <= key_vld[rd.addr];
      byp       <= wr.en && (wr.addr == rd.addr);
      byp_level <= wr.level;
    end
  end

  assign prior = byp ? byp_level : (rd_vld & ram_level);

endmodule

>>> hw/rtl/kcrb_report.sv
// ----------------------------------------------------------------------------
// kcrb_report
// Per-sample scan logic, slot filling and the registered report output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kcrb_report (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s1_valid,
  input  kcrb_pkg::key_item_t   s1_item,
  input  logic                  prior,
  input  logic                  layout,
  input  logic                  enable,
  output logic                  s1_adv,
  output kcrb_pkg::key_wr_t     wr,
  kcrb_report_if.source         rpt
);

  localparam int RS = kcrb_pkg::REPORT_SLOTS;
  localparam int FW = kcrb_pkg::FILL_W;

  kcrb_pkg::hid_code_t slots [RS];
  kcrb_pkg::hid_code_t slots_next [RS];
  logic [FW-1:0]       filled;
  logic [FW-1:0]       filled_inc;
  logic                event_seen;
  logic                event_next;
  logic                slots_full;
  logic [7:0]          prior_mods;

  kcrb_pkg::hid_code_t code;
  logic                key_act;
  logic                in_range;
  logic                key_ok;
  logic                press;
  logic                release_key;
  logic                fill_last;
  logic                mods_chg;
  logic                emit;

  logic                out_vld;
  logic [7:0]          out_mods;
  kcrb_pkg::hid_code_t out_codes [kcrb_pkg::OUT_SLOTS];
  kcrb_pkg::hid_code_t out_codes_next [kcrb_pkg::OUT_SLOTS];

  assign code        = kcrb_pkg::hid_lookup(layout, s1_item.key_index);
  assign key_act     = s1_valid && enable;
  assign in_range    = ({1'b0, s1_item.key_index} < 9'(kcrb_pkg::KEY_COUNT));
  assign key_ok      = key_act && !slots_full && in_range && (s1_item.key_down != prior);
  assign press       = key_ok && s1_item.key_down && (code != 8'h00);
  assign release_key = key_ok && !s1_item.key_down;
  assign filled_inc  = filled + FW'(1);
  assign fill_last   = press && (filled_inc >= FW'(RS));
  assign mods_chg    = key_act && s1_item.scan_last && (s1_item.modifier_bits != prior_mods);
  assign event_next  = event_seen || press || release_key;
  assign emit        = key_act && s1_item.scan_last && (event_next || mods_chg);

  assign s1_adv = s1_valid && (!emit || !out_vld || rpt.ready);

  // The press that fills the last slot is left unremembered.
  assign wr.en    = s1_adv && (release_key || (press && !fill_last));
  assign wr.addr  = s1_item.key_index[kcrb_pkg::KEY_AW-1:0];
  assign wr.level = s1_item.key_down;

  always_comb begin
    for (int j = 0; j < RS; j++) begin
      slots_next[j] = (press && (filled == FW'(j))) ? code : slots[j];
    end
  end

  for (genvar g = 0; g < kcrb_pkg::OUT_SLOTS; g++) begin : g_out
    if (g < RS) begin : g_used
      assign out_codes_next[g] = slots_next[g];
    end else begin : g_unused
      assign out_codes_next[g] = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled     <= '0;
      event_seen <= 1'b0;
      slots_full <= 1'b0;
      prior_mods <= 8'h00;
      for (int j = 0; j < RS; j++) begin
        slots[j] <= 8'h00;
      end
    end else if (s1_adv && key_act) begin
      if (s1_item.scan_last) begin
        filled     <= '0;
        event_seen <= 1'b0;
        slots_full <= 1'b0;
        prior_mods <= s1_item.modifier_bits;
        for (int j = 0; j < RS; j++) begin
          slots[j] <= 8'h00;
        end
      end else begin
        filled     <= press ? filled_inc : filled;
        event_seen <= event_next;
        slots_full <= slots_full || fill_last;
        slots      <= slots_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (s1_adv && emit) begin
      out_vld <= 1'b1;
    end else if (rpt.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_mods  <= s1_item.modifier_bits;
      out_codes <= out_codes_next;
    end
  end

  assign rpt.valid            = out_vld;
  assign rpt.report_modifiers = out_mods;
  assign rpt.slot0_code       = out_codes[0];
  assign rpt.slot1_code       = out_codes[1];
  assign rpt.slot2_code       = out_codes[2];
  assign rpt.slot3_code       = out_codes[3];
  assign rpt.slot4_code       = out_codes[4];
  assign rpt.slot5_code       = out_codes[5];

  `ASSERT_ALWAYS(a_full_matches_count, clk, rst, slots_full == (filled == FW'(RS)), "full flag out of step with slot count")
  `ASSERT_ALWAYS(a_slots_imply_event, clk, rst, (filled == '0) || event_seen, "filled slots without an event")
  `ASSERT_NEXT(a_scan_end_clears, clk, rst, s1_adv && key_act && s1_item.scan_last, (filled == '0) && !event_seen && !slots_full, "scan state not cleared at scan end")

endmodule

>>> hw/rtl/keyboard_change_report_builder.sv
// Path: an accepted key sample is held in the input stage register; its report, if any,
//   is registered onto report_out (one input register, one result register).
// Throughput: one key sample per cycle unless a held report stalls the stage; the
//   key-level RAM is read at accept, written at retire, same-address write forwarded.
// Reset: synchronous, active high; clears per-key valid bits at once (no RAM sweep),
//   scan state and modifiers; layout resets to QWERTY, enable to 1.
// ----------------------------------------------------------------------------
// keyboard_change_report_builder
// Builds HID boot-keyboard style change reports from per-key scan samples.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyboard_change_report_builder (
  input  logic          clk,
  input  logic          rst,
  kcrb_key_if.sink      key_in,
  kcrb_report_if.source report_out,
  kcrb_cfg_if.sink      cfg
);

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  logic layout;
  logic enable;

  // Stage register holding the accepted sample while the RAM read completes.
  logic                s1_valid;
  kcrb_pkg::key_item_t s1_item;
  logic                s1_adv;

  logic                accept;
  kcrb_pkg::key_rd_t   rd;
  kcrb_pkg::key_wr_t   wr;
  logic                prior;

  // Take a new beat whenever the stage is empty or moving on this cycle.
  assign key_in.ready = !s1_valid || s1_adv;
  assign accept       = key_in.valid && key_in.ready;

  // Issue the remembered-level read with the incoming beat.
  assign rd.en   = accept;
  assign rd.addr = key_in.key_index[kcrb_pkg::KEY_AW-1:0];

  // Configuration writes are always accepted and registered.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      layout <= kcrb_pkg::LAYOUT_QWERTY;
      enable <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        kcrb_pkg::CFG_LAYOUT: layout <= cfg.data[0];
        kcrb_pkg::CFG_ENABLE: enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Advance the stage: load on accept, drop when the sample retires.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.key_index     <= key_in.key_index;
      s1_item.key_down      <= key_in.key_down;
      s1_item.modifier_bits <= key_in.modifier_bits;
      s1_item.scan_last     <= key_in.scan_last;
    end
  end

  kcrb_key_state u_key_state (
    .clk   (clk),
    .rst   (rst),
    .rd    (rd),
    .wr    (wr),
    .prior (prior)
  );

  // Compare, map, fill slots and hold the finished report until taken.
  kcrb_report u_report (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .prior    (prior),
    .layout   (layout),
    .enable   (enable),
    .s1_adv   (s1_adv),
    .wr       (wr),
    .rpt      (report_out)
  );

  `ASSERT_NEXT(a_stall_holds_stage, clk, rst, s1_valid && !s1_adv, s1_valid && $stable(s1_item), "stalled beat lost")

endmodule
